>>> rtl/pvs_pkg.sv
// Shared types and constants for the Poisson variate sampler.
package pvs_pkg;

  localparam int RATE_W    = 20;   // lambda, Q4.16
  localparam int EXP_W     = 40;   // e^lambda, Q24.16
  localparam int DRAW_W    = 10;   // draw in thousandths
  localparam int COUNT_W   = 8;    // sampled count
  localparam int VAL_W     = 64;   // term, sum and threshold width
  localparam int REG_FRAC  = 16;   // fraction bits of the config registers
  localparam int MUL_A_W   = 32;   // shared multiplier, wide operand
  localparam int MUL_B_W   = 20;   // shared multiplier, narrow operand
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int FULL_W    = MUL_P_W + MUL_A_W;  // 64x20 product
  localparam int DIVD_W    = 56;   // divider dividend width
  localparam int DIV_STEPS = 8;    // quotient bits per cycle

  localparam int DRAW_SCALE = 1000;
  localparam int TERM_SCALE = 10;
  localparam int COUNT_MAX  = 255;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MEAN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_OF_RATE = 2'd1;

  localparam logic [RATE_W-1:0] RATE_RESET = 20'd65536;
  localparam logic [EXP_W-1:0]  EXP_RESET  = 40'd178145;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_MACC,
    S_DIV,
    S_ADD,
    S_CHECK,
    S_OUT
  } state_t;

endpackage

>>> rtl/pvs_mul.sv
// Shared registered unsigned multiplier.
module pvs_mul (
  input  logic                        clk,
  input  logic [pvs_pkg::MUL_A_W-1:0] a,
  input  logic [pvs_pkg::MUL_B_W-1:0] b,
  output logic [pvs_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{pvs_pkg::MUL_B_W{1'b0}}, a} * {{pvs_pkg::MUL_A_W{1'b0}}, b};
  end

endmodule

>>> rtl/pvs_div.sv
// Iterative restoring divider, several quotient bits per cycle.
module pvs_div #(
  parameter int DIVR_W = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pvs_pkg::DIVD_W-1:0] dividend,
  input  logic [DIVR_W-1:0]          divisor,
  output logic                       done,
  output logic [pvs_pkg::DIVD_W-1:0] quotient
);

  localparam int NCHUNK = pvs_pkg::DIVD_W / pvs_pkg::DIV_STEPS;
  localparam int CNT_W  = $clog2(NCHUNK + 1);

  logic [pvs_pkg::DIVD_W-1:0] quo, quo_next;
  logic [DIVR_W-1:0]          rem, rem_next;
  logic [DIVR_W-1:0]          dvs;
  logic [CNT_W-1:0]           cnt;
  logic                       run;

  // quo shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    logic [DIVR_W:0] r_ext;
    logic [DIVR_W:0] diff;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < pvs_pkg::DIV_STEPS; i++) begin
      r_ext    = {rem_next, quo_next[pvs_pkg::DIVD_W-1]};
      diff     = r_ext - {1'b0, dvs};
      quo_next = {quo_next[pvs_pkg::DIVD_W-2:0], 1'b0};
      if (r_ext >= {1'b0, dvs}) begin
        rem_next    = diff[DIVR_W-1:0];
        quo_next[0] = 1'b1;
      end else begin
        rem_next = r_ext[DIVR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= CNT_W'(NCHUNK);
    end else if (run) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/poisson_variate_sampler_core.sv
// Poisson variate sampler top level: sequencer, datapath and config registers.
//
// Usage: each transfer on the input channel (in_valid/in_ready,
// uniform_draw) carries one uniform draw in thousandths and yields exactly one
// transfer on the output channel (out_valid/out_ready, event_count) holding a
// Poisson(lambda) count. lambda (Q4.16) and e^lambda (Q24.16) are written on
// the config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while idle;
// index 0 is rate_mean, index 1 is exp_of_rate, other indexes are dropped.
// Steps: the threshold (draw * e^lambda / 1000) takes two multiplier passes,
// an accumulate and a divide; each series term takes two passes, an accumulate,
// a divide (skipped when the term saturates), an add and a check; the result is
// loaded last. Terms share one 32x20 multiplier and one divider that retires 8
// quotient bits per cycle; these set the per-term cost. One item is in work
// at a time; in_ready is high only while the sequencer is idle.
// The result sits in an output register, so a new draw is taken while the
// previous count still waits; if the receiver stalls past the end of the
// next item, the sequencer holds in its final state until the register frees.
// Reset returns lambda to 1.0, e^lambda to about e, and clears out_valid.
module poisson_variate_sampler_core #(
  parameter int MIN_TERMS = 100,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pvs_pkg::DRAW_W-1:0]    uniform_draw,
  // output channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pvs_pkg::COUNT_W-1:0]   event_count,
  // config channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pvs_pkg::EXP_W-1:0]     cfg_data
);

  localparam int CAP_MAX = (MIN_TERMS > 150) ? MIN_TERMS : 150;
  localparam int CAP_W   = $clog2(CAP_MAX + 1);
  localparam int DIVR_W  = (CAP_W > 10) ? CAP_W : 10;
  localparam int SH_L    = (FRAC_BITS >= pvs_pkg::REG_FRAC) ? FRAC_BITS - pvs_pkg::REG_FRAC : 0;
  localparam int SH_R    = (FRAC_BITS < pvs_pkg::REG_FRAC) ? pvs_pkg::REG_FRAC - FRAC_BITS : 0;
  localparam logic [pvs_pkg::VAL_W-1:0] ONE = pvs_pkg::VAL_W'(1) << FRAC_BITS;

  pvs_pkg::state_t state, state_next;

  // config registers
  logic [pvs_pkg::RATE_W-1:0] rate_mean;
  logic [pvs_pkg::EXP_W-1:0]  exp_of_rate;

  // per-item working registers
  logic [pvs_pkg::DRAW_W-1:0]  draw;
  logic                        thr_phase;   // 1 while forming the threshold
  logic [pvs_pkg::VAL_W-1:0]   term, sum, thr;
  logic [CAP_W-1:0]            k;
  logic [pvs_pkg::MUL_P_W-1:0] acc_lo;

  // shared units
  logic [pvs_pkg::MUL_A_W-1:0] mul_a;
  logic [pvs_pkg::MUL_B_W-1:0] mul_b;
  logic [pvs_pkg::MUL_P_W-1:0] mul_p;
  logic                        div_start, div_done;
  logic [pvs_pkg::DIVD_W-1:0]  div_dividend, div_quot;
  logic [DIVR_W-1:0]           div_divisor;

  logic [pvs_pkg::FULL_W-1:0]  full;
  logic                        term_ovf;
  logic [7:0]                  alt;
  logic [CAP_W-1:0]            cap;
  logic                        go_on;
  logic                        out_load;
  logic [pvs_pkg::VAL_W:0]     sum_add;
  logic [pvs_pkg::VAL_W-1:0]   quot_ext;
  logic [CAP_W-1:0]            cnt_m1;

  pvs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  pvs_div #(
    .DIVR_W (DIVR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // ---------------- datapath ----------------
  // low partial product plus high partial product shifted up by 32
  assign full = {{pvs_pkg::MUL_A_W{1'b0}}, acc_lo} + {mul_p, {pvs_pkg::MUL_A_W{1'b0}}};
  // term * lambda does not fit in 64 bits: term saturates
  assign term_ovf = !thr_phase && (full[pvs_pkg::FULL_W-1:pvs_pkg::VAL_W] != '0);

  assign div_dividend = thr_phase ? full[pvs_pkg::DIVD_W-1:0]
                                  : pvs_pkg::DIVD_W'(full[pvs_pkg::VAL_W-1:pvs_pkg::REG_FRAC]);
  assign div_divisor  = thr_phase ? DIVR_W'(pvs_pkg::DRAW_SCALE) : DIVR_W'(k);
  assign quot_ext     = pvs_pkg::VAL_W'(div_quot);

  assign sum_add = {1'b0, sum} + {1'b0, term};

  // term cap: max(MIN_TERMS, 10 * floor(lambda)); 10x = 8x + 2x
  assign alt = ({4'd0, rate_mean[pvs_pkg::RATE_W-1:pvs_pkg::REG_FRAC]} << 3)
             + ({4'd0, rate_mean[pvs_pkg::RATE_W-1:pvs_pkg::REG_FRAC]} << 1);
  assign cap = (CAP_W'(alt) > CAP_W'(MIN_TERMS)) ? CAP_W'(alt) : CAP_W'(MIN_TERMS);

  assign go_on  = (k < cap) && (sum <= thr);
  assign cnt_m1 = k - CAP_W'(1);

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      pvs_pkg::S_IDLE:  if (in_valid) state_next = pvs_pkg::S_MLO;
      pvs_pkg::S_MLO:   state_next = pvs_pkg::S_MHI;
      pvs_pkg::S_MHI:   state_next = pvs_pkg::S_MACC;
      pvs_pkg::S_MACC:  state_next = term_ovf ? pvs_pkg::S_ADD : pvs_pkg::S_DIV;
      pvs_pkg::S_DIV: begin
        if (div_done) state_next = thr_phase ? pvs_pkg::S_CHECK : pvs_pkg::S_ADD;
      end
      pvs_pkg::S_ADD:   state_next = pvs_pkg::S_CHECK;
      pvs_pkg::S_CHECK: state_next = go_on ? pvs_pkg::S_MLO : pvs_pkg::S_OUT;
      pvs_pkg::S_OUT:   if (!out_valid || out_ready) state_next = pvs_pkg::S_IDLE;
      default:          state_next = pvs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    mul_a     = term[pvs_pkg::MUL_A_W-1:0];
    mul_b     = rate_mean;
    case (state)
      pvs_pkg::S_IDLE: in_ready = !rst;
      pvs_pkg::S_MLO: begin
        mul_a = thr_phase ? exp_of_rate[pvs_pkg::MUL_A_W-1:0] : term[pvs_pkg::MUL_A_W-1:0];
        mul_b = thr_phase ? pvs_pkg::MUL_B_W'(draw) : rate_mean;
      end
      pvs_pkg::S_MHI: begin
        mul_a = thr_phase ? pvs_pkg::MUL_A_W'(exp_of_rate[pvs_pkg::EXP_W-1:pvs_pkg::MUL_A_W])
                          : term[pvs_pkg::VAL_W-1:pvs_pkg::MUL_A_W];
        mul_b = thr_phase ? pvs_pkg::MUL_B_W'(draw) : rate_mean;
      end
      pvs_pkg::S_MACC: div_start = !term_ovf;
      pvs_pkg::S_OUT:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config registers; writes taken only while idle and out of reset
  assign cfg_ready = !rst && (state == pvs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mean   <= pvs_pkg::RATE_RESET;
      exp_of_rate <= pvs_pkg::EXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pvs_pkg::CFG_RATE_MEAN:   rate_mean   <= cfg_data[pvs_pkg::RATE_W-1:0];
        pvs_pkg::CFG_EXP_OF_RATE: exp_of_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      pvs_pkg::S_IDLE: begin
        if (in_valid) begin
          draw      <= uniform_draw;
          thr_phase <= 1'b1;
          term      <= ONE;
          sum       <= ONE;
          k         <= CAP_W'(1);
        end
      end
      pvs_pkg::S_MHI:  acc_lo <= mul_p;
      pvs_pkg::S_MACC: if (term_ovf) term <= '1;
      pvs_pkg::S_DIV: begin
        if (div_done) begin
          if (thr_phase) begin
            thr       <= (quot_ext << SH_L) >> SH_R;
            thr_phase <= 1'b0;
          end else begin
            term <= quot_ext;
          end
        end
      end
      pvs_pkg::S_ADD: begin
        sum <= sum_add[pvs_pkg::VAL_W] ? '1 : sum_add[pvs_pkg::VAL_W-1:0];
        k   <= k + CAP_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_count <= (cnt_m1 > CAP_W'(pvs_pkg::COUNT_MAX)) ? '1 : cnt_m1[pvs_pkg::COUNT_W-1:0];
    end
  end

  // ---------------- assertions ----------------
  a_k_within_cap: assert property (@(posedge clk) disable iff (rst)
    (state != pvs_pkg::S_IDLE) |-> (k <= cap))
    else $error("term index ran past the cap");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == pvs_pkg::S_DIV))
    else $error("divider finished outside the divide step");

  a_sum_at_least_one: assert property (@(posedge clk) disable iff (rst)
    (state == pvs_pkg::S_CHECK) |-> (sum >= ONE))
    else $error("running sum fell below one");

  a_accept_inits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (k == CAP_W'(1) && thr_phase && state == pvs_pkg::S_MLO))
    else $error("accepted draw did not start a fresh series");

  a_load_frees_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result overwrote a count not yet taken");

endmodule

>>> tb/sv/tb.sv
// Testbench for poisson_variate_sampler_core: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module tb;
  import pvs_pkg::*;

  // DUT build parameters. The predictor below uses the same values.
  localparam int MIN_TERMS = 100;
  localparam int FRAC_BITS = 16;

  // Config indexes that the block has no register for. Writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
  localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
  localparam int RATE_ONE = 1 << REG_FRAC;

  localparam int RANDOM_DRAWS  = 1428;  // random part; the directed table adds 22 more
  localparam int MAX_IDLE      = 13;    // longest sender gap or receiver stall, in cycles
  localparam int DRAIN_LIMIT   = 20000; // cycles allowed for outstanding counts to come back
  localparam int SETTLE_CYCLES = 16;    // quiet cycles after the last count, before a write
  localparam int NO_COUNT      = -1;    // table entry has no typed-in count; use the predictor

  // One row of the directed table: the config it runs under, the draw, and an optional
  // count that can be read straight off the spec.
  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [EXP_W-1:0]   expv;
    logic [DRAW_W-1:0]  draw;
    logic               known;
    logic [COUNT_W-1:0] count;
  } draw_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [DRAW_W-1:0]    uniform_draw;
  logic                 out_valid;
  logic                 out_ready;
  logic [COUNT_W-1:0]   event_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [EXP_W-1:0]     cfg_data;

  // Shadow copies of the two registers, updated on every config transfer to them.
  logic [RATE_W-1:0] cur_rate;
  logic [EXP_W-1:0]  cur_exp;

  logic [COUNT_W-1:0] expected_counts[$];  // one per accepted draw, oldest first
  draw_row_t          draw_table[$];

  int fail_count;
  bit send_idle;  // per-phase switches, so that some stretches run with no gaps at all
  bit recv_idle;

  poisson_variate_sampler_core #(
    .MIN_TERMS(MIN_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .uniform_draw(uniform_draw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_count(event_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 12 ns clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Sum of lambda^k/k! in Q.16, built with the same truncating recurrence that the block
  // uses. Feeding this back as exp_of_rate keeps the threshold under the final series sum,
  // so in-range draws finish well before the term cap.
  function automatic logic [EXP_W-1:0] exp_series_q16(input logic [RATE_W-1:0] rate);
    logic [VAL_W-1:0] term;
    logic [VAL_W-1:0] sum;
    int k;
    term = VAL_W'(RATE_ONE);
    sum  = term;
    for (k = 1; k < 200; k++) begin
      term = ((term * rate) >> REG_FRAC) / VAL_W'(k);
      sum  = sum + term;
    end
    if (sum > VAL_W'(EXP_MAX)) return EXP_MAX;
    return sum[EXP_W-1:0];
  endfunction

  // Expected count for one draw: walk the inverse-transform series in fixed point until the
  // running sum passes the threshold or the term cap is hit.
  function automatic logic [COUNT_W-1:0] poisson_count(input logic [DRAW_W-1:0] draw,
                                                       input logic [RATE_W-1:0] rate,
                                                       input logic [EXP_W-1:0]  expv);
    logic [VAL_W-1:0]        thr;
    logic [VAL_W-1:0]        term;
    logic [VAL_W-1:0]        sum;
    logic [VAL_W+RATE_W-1:0] prod;
    logic [VAL_W:0]          acc;
    int cap;
    int k;
    thr = (VAL_W'(draw) * VAL_W'(expv)) / VAL_W'(DRAW_SCALE);
    if (FRAC_BITS >= REG_FRAC) thr = thr << (FRAC_BITS - REG_FRAC);
    else thr = thr >> (REG_FRAC - FRAC_BITS);
    term = VAL_W'(1) << FRAC_BITS;
    sum  = term;
    // Cap is max(MIN_TERMS, 10 * floor(lambda)).
    cap = MIN_TERMS;
    if (TERM_SCALE * int'(rate >> REG_FRAC) > cap) cap = TERM_SCALE * int'(rate >> REG_FRAC);
    k = 1;
    while (k < cap && sum <= thr) begin
      prod = VAL_W'(term) * (VAL_W+RATE_W)'(rate);
      // Term saturates when the 64-bit product would overflow.
      if (prod[VAL_W+RATE_W-1:VAL_W] != '0) term = '1;
      else term = (prod[VAL_W-1:0] >> REG_FRAC) / VAL_W'(k);
      // Sum saturates too; that always stops the walk.
      acc = (VAL_W+1)'(sum) + (VAL_W+1)'(term);
      sum = acc[VAL_W] ? '1 : acc[VAL_W-1:0];
      k++;
    end
    if (k - 1 > COUNT_MAX) return COUNT_W'(COUNT_MAX);
    return COUNT_W'(k - 1);
  endfunction

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic add_row(input logic [RATE_W-1:0] rate, input logic [EXP_W-1:0] expv,
                         input logic [DRAW_W-1:0] draw, input int count);
    draw_row_t row;
    row.rate  = rate;
    row.expv  = expv;
    row.draw  = draw;
    row.known = (count != NO_COUNT);
    row.count = (count == NO_COUNT) ? '0 : COUNT_W'(count);
    draw_table.push_back(row);
  endtask

  // Offer one draw. Valid is only dropped when a gap is drawn, so back-to-back
  // transfers keep it high without a low/high pair in the same step.
  // The expected count is queued on the accepting edge.
  task automatic send_draw(input logic [DRAW_W-1:0] draw, input int count);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    uniform_draw <= draw;
    do @(posedge clk); while (!in_ready);
    if (count == NO_COUNT) expected_counts.push_back(poisson_count(draw, cur_rate, cur_exp));
    else expected_counts.push_back(COUNT_W'(count));
  endtask

  // Stop offering draws and wait until every outstanding count is back, then give the
  // block a few quiet cycles. A count that never comes is a failure; the run moves on.
  task automatic drain_counts();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_counts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_counts.size() != 0) begin
      report_failure($sformatf("%0d count(s) never arrived, next expected %0d",
                               expected_counts.size(), expected_counts[0]));
      expected_counts.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers in one burst with cfg_valid held high. Optionally a write to an
  // unused index goes first; the block must drop it. rate_word may carry junk above bit 19.
  task automatic write_config(input logic [EXP_W-1:0] rate_word, input logic [EXP_W-1:0] expv,
                              input bit spare);
    logic [CFG_IDX_W-1:0] idx[3];
    logic [EXP_W-1:0]     dat[3];
    int n_writes;
    int n;
    n_writes = 0;
    if (spare) begin
      idx[n_writes] = $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI;
      dat[n_writes] = EXP_W'({$urandom, $urandom});
      n_writes++;
    end
    idx[n_writes] = CFG_RATE_MEAN;
    dat[n_writes] = rate_word;
    n_writes++;
    idx[n_writes] = CFG_EXP_OF_RATE;
    dat[n_writes] = expv;
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b1;
    for (n = 0; n < n_writes; n++) begin
      if (n > 0) @(negedge clk);
      cfg_index <= idx[n];
      cfg_data  <= dat[n];
      do @(posedge clk); while (!cfg_ready);
      if (idx[n] == CFG_RATE_MEAN) cur_rate = dat[n][RATE_W-1:0];
      else if (idx[n] == CFG_EXP_OF_RATE) cur_exp = dat[n];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall a random number of cycles per count, then hold ready until the
  // transfer. Each count is checked against the oldest expectation.
  initial begin
    int stall;
    logic [COUNT_W-1:0] want;
    wait (rst === 1'b0);
    forever begin
      stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (expected_counts.size() == 0) begin
        report_failure($sformatf("count %0d with no draw outstanding", event_count));
      end else begin
        want = expected_counts.pop_front();
        if (event_count !== want)
          report_failure($sformatf("event_count expected %0d got %0d", want, event_count));
      end
    end
  end

  // Main stimulus.
  initial begin
    int i;
    int sent;
    int phase_draws;
    logic [RATE_W-1:0]  rate;
    logic [EXP_W-1:0]   expv;
    logic [EXP_W-1:0]   rate_word;
    logic [DRAW_W-1:0]  draw;
    bit slow;
    draw_row_t row;

    // Every input known from time zero.
    rst          = 1'b1;
    in_valid     = 1'b0;
    uniform_draw = '0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_RATE_MEAN;
    cfg_data     = '0;
    fail_count   = 0;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    cur_rate     = RATE_RESET;
    cur_exp      = EXP_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Typed-in counts: a zero draw always gives 0; a draw above 999 with a
    // consistent e^lambda runs to the cap (cap - 1); zero lambda gives 0 below 1.0 and the
    // cap at or above it; zero e^lambda gives a zero threshold.
    // Registers at reset (lambda = 1, e^lambda ~ e).
    add_row(RATE_RESET, EXP_RESET, 10'd0, 0);
    add_row(RATE_RESET, EXP_RESET, 10'd999, NO_COUNT);
    add_row(RATE_RESET, EXP_RESET, 10'd500, NO_COUNT);
    add_row(RATE_RESET, EXP_RESET, 10'd341, NO_COUNT);
    add_row(RATE_RESET, EXP_RESET, 10'd682, NO_COUNT);
    add_row(RATE_RESET, EXP_RESET, 10'd1023, MIN_TERMS - 1);
    // Zero lambda, e^lambda = 1.0.
    add_row('0, EXP_W'(RATE_ONE), 10'd0, 0);
    add_row('0, EXP_W'(RATE_ONE), 10'd999, 0);
    add_row('0, EXP_W'(RATE_ONE), 10'd1000, MIN_TERMS - 1);
    // Largest lambda, cap 150.
    add_row(RATE_MAX, exp_series_q16(RATE_MAX), 10'd0, 0);
    add_row(RATE_MAX, exp_series_q16(RATE_MAX), 10'd1, NO_COUNT);
    add_row(RATE_MAX, exp_series_q16(RATE_MAX), 10'd999, NO_COUNT);
    add_row(RATE_MAX, exp_series_q16(RATE_MAX), 10'd1023, TERM_SCALE * 15 - 1);
    // lambda = 11.0 lifts the cap to 110.
    add_row(RATE_W'(11 * RATE_ONE), exp_series_q16(RATE_W'(11 * RATE_ONE)), 10'd1023,
            TERM_SCALE * 11 - 1);
    add_row(RATE_W'(11 * RATE_ONE), exp_series_q16(RATE_W'(11 * RATE_ONE)), 10'd512, NO_COUNT);
    // Zero e^lambda.
    add_row(RATE_RESET, '0, 10'd999, 0);
    // Smallest nonzero lambda against the largest e^lambda: never reaches the threshold.
    add_row(RATE_W'(1), EXP_MAX, 10'd999, MIN_TERMS - 1);
    add_row(RATE_W'(1), EXP_MAX, 10'd3, NO_COUNT);
    // lambda just under 1.0.
    add_row(RATE_W'(RATE_ONE - 1), exp_series_q16(RATE_W'(RATE_ONE - 1)), 10'd999, NO_COUNT);
    add_row(RATE_W'(RATE_ONE - 1), exp_series_q16(RATE_W'(RATE_ONE - 1)), 10'd250, NO_COUNT);
    // lambda = 3.5 with e^lambda understated by half.
    add_row(RATE_W'(7 * RATE_ONE / 2), exp_series_q16(RATE_W'(7 * RATE_ONE / 2)) >> 1,
            10'd999, NO_COUNT);
    add_row(RATE_W'(7 * RATE_ONE / 2), exp_series_q16(RATE_W'(7 * RATE_ONE / 2)) >> 1,
            10'd300, NO_COUNT);

    foreach (draw_table[i]) begin
      row = draw_table[i];
      if (row.rate != cur_rate || row.expv != cur_exp) begin
        drain_counts();
        write_config(EXP_W'(row.rate), row.expv, 1'b1);
      end
      send_draw(row.draw, row.known ? int'(row.count) : NO_COUNT);
    end

    // Random phases: new register settings between phases, idling switched per phase.
    sent = 0;
    while (sent < RANDOM_DRAWS) begin
      drain_counts();

      case ($urandom_range(0, 3))
        0: rate = RATE_W'($urandom_range(0, (1 << RATE_W) - 1));
        1: rate = RATE_W'($urandom_range(0, 4 * RATE_ONE));   // small lambda
        2: rate = RATE_W'($urandom_range(0, 15) * RATE_ONE);  // whole lambda, cap steps
        default: begin
          case ($urandom_range(0, 3))
            0: rate = '0;
            1: rate = RATE_W'(1);
            2: rate = RATE_W'(RATE_ONE - 1);
            default: rate = RATE_MAX;
          endcase
        end
      endcase

      // Mostly a consistent e^lambda; sometimes off, which pushes draws to the cap.
      expv = exp_series_q16(rate);
      slow = 1'b0;
      case ($urandom_range(0, 9))
        6: expv = expv >> 1;
        7: expv = expv + (expv >> 2);
        8: begin
          expv = EXP_W'({$urandom, $urandom});
          slow = 1'b1;
        end
        9: begin
          if ($urandom_range(0, 1)) expv = '0;
          else begin
            expv = EXP_MAX;
            slow = 1'b1;
          end
        end
        default: ;
      endcase

      rate_word = EXP_W'(rate);
      if ($urandom_range(0, 1)) rate_word[EXP_W-1:RATE_W] = (EXP_W-RATE_W)'($urandom);
      write_config(rate_word, expv, $urandom_range(0, 2) == 0);

      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);

      // Phases where every draw runs to the cap are kept short.
      phase_draws = slow ? 30 : $urandom_range(100, 180);
      for (i = 0; i < phase_draws && sent < RANDOM_DRAWS; i++) begin
        case ($urandom_range(0, 99)) inside
          [0:95]:  draw = DRAW_W'($urandom_range(0, DRAW_SCALE - 1));
          [96:97]: draw = DRAW_W'($urandom_range(DRAW_SCALE, (1 << DRAW_W) - 1));
          default: draw = DRAW_W'($urandom);
        endcase
        send_draw(draw, NO_COUNT);
        sent++;
      end
    end

    drain_counts();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog, several times the slowest legal run (every draw at the cap, maximum idling).
  initial begin
    #250_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
